// File: rtl/core/mrbf_pkg.sv
// Shared types and constants for the multi-reader broadcast FIFO.
// Holds the payload structs, request/status codes and the ring index helper.
// No dependencies.
package mrbf_pkg;

  localparam int unsigned Depth        = 16;
  localparam int unsigned AddrW        = $clog2(Depth);
  localparam int unsigned CntW         = $clog2(Depth + 1);
  localparam int unsigned MaxConsumers = 8;
  localparam int unsigned IdW          = $clog2(MaxConsumers);
  localparam int unsigned DataW        = 32;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 5;

  typedef enum logic [1:0] {
    KindRegister = 2'd0,
    KindRemove   = 2'd1,
    KindGet      = 2'd2,
    KindPut      = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StEmpty   = 3'd1,
    StWait    = 3'd2,
    StFull    = 3'd3,
    StDropped = 3'd4,
    StBadId   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    PolDiscard = 2'd0,
    PolRefuse  = 2'd1,
    PolReplace = 2'd2,
    PolOther   = 2'd3
  } policy_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPutPolicy = 2'd0,
    CfgCapacity  = 2'd1,
    CfgUnused2   = 2'd2,
    CfgUnused3   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  consumer_id;
    logic [31:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] read_data;
    logic [2:0]  assigned_id;
    logic [4:0]  occupancy;
  } out_item_t;

  // Request to the consumer flag table
  typedef struct packed {
    logic           reg_en;
    logic           remove_en;
    logic           mark_en;
    logic           clear_en;
    logic [IdW-1:0] id;
  } cons_cmd_t;

  // Flag table status, valid for the id carried in the command
  typedef struct packed {
    logic           free_found;
    logic [IdW-1:0] free_id;
    logic           id_has_read;
    logic           all_read;
  } cons_stat_t;

  // Step a ring index, wrapping at the effective capacity
  function automatic logic [AddrW-1:0] ring_adv(logic [AddrW-1:0] idx,
                                                logic [CntW-1:0]  cap);
    logic [CntW-1:0] nxt;
    nxt = CntW'(idx) + CntW'(1);
    return (nxt >= cap) ? '0 : nxt[AddrW-1:0];
  endfunction

endpackage

// File: rtl/core/mrbf_consumers.sv
// Consumer flag table: active and has-read bits for every consumer slot.
// Finds the lowest free slot and tells when all active consumers but the commanded one have read.
// Depends on mrbf_pkg.
module mrbf_consumers
  import mrbf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cons_cmd_t  cmd_i,
  output cons_stat_t stat_o
);

  logic [MaxConsumers-1:0] active_q, active_d;
  logic [MaxConsumers-1:0] read_q, read_d;
  logic [MaxConsumers-1:0] id_mask;

  assign id_mask = MaxConsumers'(1) << cmd_i.id;

  always_comb begin
    stat_o.free_found = 1'b0;
    stat_o.free_id    = '0;
    // scan from the top so the lowest free slot wins
    for (int i = MaxConsumers - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        stat_o.free_found = 1'b1;
        stat_o.free_id    = IdW'(i);
      end
    end
    stat_o.id_has_read = read_q[cmd_i.id];
    stat_o.all_read    = &(~active_q | read_q | id_mask);
  end

  always_comb begin
    active_d = active_q;
    read_d   = read_q;
    if (cmd_i.mark_en) begin
      read_d = read_d | id_mask;
    end
    if (cmd_i.clear_en) begin
      read_d = read_d & ~active_q;
    end
    if (cmd_i.reg_en) begin
      active_d[stat_o.free_id] = 1'b1;
      read_d[stat_o.free_id]   = 1'b0;
    end
    if (cmd_i.remove_en) begin
      active_d[cmd_i.id] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      read_q   <= '0;
    end else begin
      active_q <= active_d;
      read_q   <= read_d;
    end
  end

endmodule

// File: rtl/core/multi_reader_broadcast_fifo_core.sv
// Top level of the multi-reader broadcast FIFO: request decode, word ring,
// configuration registers and result register. Uses mrbf_pkg, mrbf_consumers.

// Takes one request per clock cycle while the output is not stalled and
// returns exactly one result per request, in order. A request is held in
// the input register, where it is decoded against the ring and consumer
// state, and its result is then registered in the output register.
// Output stalls back up into the input register one stage at a time.
// Configuration writes are always taken
// (cfg_ready_o is tied high) and must only be issued while no request is in
// flight; index 0 is put_policy, index 1 is capacity, other indexes are ignored.
module multi_reader_broadcast_fifo_core
  import mrbf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic            in_vld_q;
  in_item_t        in_q;
  logic            out_vld_q;
  out_item_t       out_q, out_d;
  logic [1:0]      policy_q;
  logic [CntW-1:0] cap_q;
  logic [CntW-1:0] eff_cap;

  logic [DataW-1:0] store_q [Depth];
  logic [AddrW-1:0] head_q, head_d;
  logic [AddrW-1:0] tail_q, tail_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             wr_en;
  logic             go;
  logic             bad_id;
  logic             ring_full;

  cons_cmd_t  cmd;
  cons_stat_t stat;

  mrbf_consumers u_consumers (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  assign go          = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o  = !in_vld_q || go;
  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // clamp capacity into 1..Depth
  assign eff_cap = (cap_q == '0) ? CntW'(1) :
                   (cap_q > CntW'(Depth)) ? CntW'(Depth) : cap_q;

  assign bad_id    = (CntW'(in_q.consumer_id) >= CntW'(MaxConsumers));
  assign ring_full = (count_q >= eff_cap);

  always_comb begin
    logic ins;
    ins               = 1'b0;
    out_d.status      = StOk;
    out_d.read_data   = '0;
    out_d.assigned_id = '0;
    cmd.reg_en        = 1'b0;
    cmd.remove_en     = 1'b0;
    cmd.mark_en       = 1'b0;
    cmd.clear_en      = 1'b0;
    cmd.id            = in_q.consumer_id[IdW-1:0];
    head_d            = head_q;
    tail_d            = tail_q;
    count_d           = count_q;
    wr_en             = 1'b0;

    unique case (in_q.kind)
      KindRegister: begin
        if (stat.free_found) begin
          cmd.reg_en        = 1'b1;
          out_d.assigned_id = stat.free_id;
        end else begin
          out_d.status = StFull;
        end
      end
      KindRemove: begin
        if (bad_id) begin
          out_d.status = StBadId;
        end else begin
          cmd.remove_en = 1'b1;
        end
      end
      KindGet: begin
        if (bad_id) begin
          out_d.status = StBadId;
        end else if (count_q == '0) begin
          out_d.status = StEmpty;
        end else if (stat.id_has_read) begin
          out_d.status = StWait;
        end else begin
          out_d.read_data = store_q[head_q];
          cmd.mark_en     = 1'b1;
          // last reader frees the head
          if (stat.all_read) begin
            cmd.clear_en = 1'b1;
            head_d       = ring_adv(head_q, eff_cap);
            count_d      = count_q - CntW'(1);
          end
        end
      end
      KindPut: begin
        ins = 1'b1;
        if (count_q == '0) begin
          cmd.clear_en = 1'b1;
        end
        if (ring_full) begin
          case (in_q.kind == KindPut ? policy_q : PolRefuse)
            PolDiscard: begin
              out_d.status = StDropped;
              ins          = 1'b0;
            end
            PolReplace: begin
              // drop the oldest word to make room
              cmd.clear_en = 1'b1;
              head_d       = ring_adv(head_q, eff_cap);
              count_d      = count_q - CntW'(1);
            end
            default: begin
              out_d.status = StFull;
              ins          = 1'b0;
            end
          endcase
        end
        if (ins) begin
          wr_en   = 1'b1;
          tail_d  = ring_adv(tail_q, eff_cap);
          count_d = count_d + CntW'(1);
        end
      end
      default: begin
        out_d.status = StOk;
      end
    endcase

    if (!go) begin
      cmd.reg_en    = 1'b0;
      cmd.remove_en = 1'b0;
      cmd.mark_en   = 1'b0;
      cmd.clear_en  = 1'b0;
      wr_en         = 1'b0;
      head_d        = head_q;
      tail_d        = tail_q;
      count_d       = count_q;
    end
    out_d.occupancy = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      policy_q  <= PolDiscard;
      cap_q     <= CntW'(Depth);
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (go) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgPutPolicy: policy_q <= cfg_data_i[1:0];
          CfgCapacity:  cap_q    <= cfg_data_i;
          default:      policy_q <= policy_q;
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_item_i;
    end
    if (go) begin
      out_q <= out_d;
    end
    if (wr_en) begin
      store_q[tail_q] <= in_q.write_data;
    end
  end

endmodule
